[design/ptcs_pkg.sv]
// ----------------------------------------------------------------------------
// ptcs_pkg - shared types, codes and cue ROM for the tone cue sequencer
// Command codes, result word layout, pattern tables and priorities.
// ----------------------------------------------------------------------------
`default_nettype none

package ptcs_pkg;

  // longest pattern that is played; longer patterns are cut
  localparam int MAX_PATTERN_STEPS = 5;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_ALARM = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_REPEAT = 1'b1;

  localparam logic [2:0] CUE_ALARM = 3'd5;
  localparam logic [2:0] PRIO_ALARM = 3'd5;
  localparam logic [15:0] REPEAT_RESET = 16'd5000;

  // result word; packs with tone_hz in the low bits
  typedef struct packed {
    logic        alarm_latched;
    logic [2:0]  current_cue;
    logic        sounding;
    logic [11:0] tone_hz;
  } res_t;

  function automatic logic [11:0] cue_hz(input logic [2:0] c, input logic [2:0] s);
    logic [11:0] hz;
    case ({c, s})
      {3'd0, 3'd0}: hz = 12'd2400;
      {3'd1, 3'd0}: hz = 12'd1400;
      {3'd2, 3'd0}: hz = 12'd1800;
      {3'd2, 3'd2}: hz = 12'd2400;
      {3'd3, 3'd0}: hz = 12'd1000;
      {3'd3, 3'd2}: hz = 12'd1000;
      {3'd4, 3'd0}: hz = 12'd1800;
      {3'd4, 3'd2}: hz = 12'd2200;
      {3'd4, 3'd4}: hz = 12'd2800;
      {3'd5, 3'd0}: hz = 12'd700;
      {3'd5, 3'd2}: hz = 12'd700;
      {3'd5, 3'd4}: hz = 12'd700;
      default:      hz = 12'd0;
    endcase
    return hz;
  endfunction

  function automatic logic [7:0] cue_ms(input logic [2:0] c, input logic [2:0] s);
    logic [7:0] ms;
    case ({c, s})
      {3'd0, 3'd0}: ms = 8'd35;
      {3'd1, 3'd0}: ms = 8'd60;
      {3'd2, 3'd0}: ms = 8'd70;
      {3'd2, 3'd1}: ms = 8'd45;
      {3'd2, 3'd2}: ms = 8'd90;
      {3'd3, 3'd0}: ms = 8'd180;
      {3'd3, 3'd1}: ms = 8'd100;
      {3'd3, 3'd2}: ms = 8'd180;
      {3'd4, 3'd0}: ms = 8'd100;
      {3'd4, 3'd1}: ms = 8'd80;
      {3'd4, 3'd2}: ms = 8'd100;
      {3'd4, 3'd3}: ms = 8'd80;
      {3'd4, 3'd4}: ms = 8'd150;
      {3'd5, 3'd0}: ms = 8'd250;
      {3'd5, 3'd1}: ms = 8'd120;
      {3'd5, 3'd2}: ms = 8'd250;
      {3'd5, 3'd3}: ms = 8'd120;
      {3'd5, 3'd4}: ms = 8'd250;
      default:      ms = 8'd0;
    endcase
    return ms;
  endfunction

  // number of steps played, already cut to MAX_PATTERN_STEPS
  function automatic logic [3:0] cue_steps(input logic [2:0] c);
    logic [3:0] n;
    case (c)
      3'd0, 3'd1: n = 4'd1;
      3'd2, 3'd3: n = 4'd3;
      3'd4, 3'd5: n = 4'd5;
      default:    n = 4'd0;
    endcase
    if (n > 4'(MAX_PATTERN_STEPS)) begin
      n = 4'(MAX_PATTERN_STEPS);
    end
    return n;
  endfunction

  function automatic logic [2:0] cue_prio(input logic [2:0] c);
    logic [2:0] p;
    case (c)
      3'd0, 3'd1: p = 3'd1;
      3'd2:       p = 3'd2;
      3'd3:       p = 3'd4;
      3'd4:       p = 3'd3;
      3'd5:       p = PRIO_ALARM;
      default:    p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[design/ptcs_core.sv]
// ----------------------------------------------------------------------------
// ptcs_core - cue sequencer state and command decode
// Applies one command per accepted word and forms the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcs_core #(
  parameter int GAP_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  input  wire logic            cfg_index,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            accept,
  input  wire ptcs_pkg::cmd_t  cmd,
  input  wire logic [2:0]      cue,
  input  wire logic            alarm_request,
  output ptcs_pkg::res_t       res
);
  import ptcs_pkg::*;

  localparam int CW = (GAP_BITS > 16) ? GAP_BITS : 16;
  localparam logic [GAP_BITS-1:0] GAP_MAX = {GAP_BITS{1'b1}};

  logic                enable;
  logic [15:0]         alarm_repeat_ms;

  logic                pattern_busy, pattern_busy_next;
  logic [2:0]          pattern_cue, pattern_cue_next;
  logic [2:0]          step_number, step_number_next;
  logic [2:0]          busy_priority, busy_priority_next;
  logic [7:0]          step_elapsed, step_elapsed_next;
  logic [GAP_BITS-1:0] alarm_gap, alarm_gap_next;
  logic                alarm_mode, alarm_mode_next;
  logic [11:0]         tone_reg, tone_reg_next;

  logic [7:0]          dur;
  logic [7:0]          elapsed_inc;
  logic [3:0]          step_inc;
  logic [CW-1:0]       repeat_ext;
  logic [GAP_BITS-1:0] repeat_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      alarm_repeat_ms <= REPEAT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ENABLE) begin
        enable <= cfg_data[0];
      end else begin
        alarm_repeat_ms <= cfg_data;
      end
    end
  end

  assign dur         = cue_ms(pattern_cue, step_number);
  assign elapsed_inc = (step_elapsed != 8'hFF) ? step_elapsed + 8'd1 : step_elapsed;
  assign step_inc    = {1'b0, step_number} + 4'd1;
  assign repeat_ext  = CW'(alarm_repeat_ms);
  assign repeat_sat  = (repeat_ext > CW'(GAP_MAX)) ? GAP_MAX : GAP_BITS'(repeat_ext);

  always_comb begin
    pattern_busy_next  = pattern_busy;
    pattern_cue_next   = pattern_cue;
    step_number_next   = step_number;
    busy_priority_next = busy_priority;
    step_elapsed_next  = step_elapsed;
    alarm_gap_next     = alarm_gap;
    alarm_mode_next    = alarm_mode;
    tone_reg_next      = tone_reg;

    if (accept && enable) begin
      unique case (cmd)
        CMD_TICK: begin
          if (alarm_gap != GAP_MAX) begin
            alarm_gap_next = alarm_gap + GAP_BITS'(1);
          end
          if (pattern_busy) begin
            if (elapsed_inc >= dur) begin
              if (step_inc >= cue_steps(pattern_cue)) begin
                if (pattern_cue == CUE_ALARM) begin
                  alarm_gap_next = '0;
                end
                pattern_busy_next  = 1'b0;
                step_number_next   = 3'd0;
                busy_priority_next = 3'd0;
                step_elapsed_next  = 8'd0;
                tone_reg_next      = 12'd0;
              end else begin
                step_number_next  = step_inc[2:0];
                tone_reg_next     = cue_hz(pattern_cue, step_inc[2:0]);
                step_elapsed_next = 8'd0;
              end
            end else begin
              step_elapsed_next = elapsed_inc;
            end
          end
          // alarm replay once the gap has run out
          if (alarm_mode && !pattern_busy_next && (CW'(alarm_gap_next) >= repeat_ext)) begin
            pattern_cue_next   = CUE_ALARM;
            pattern_busy_next  = 1'b1;
            step_number_next   = 3'd0;
            busy_priority_next = PRIO_ALARM;
            tone_reg_next      = cue_hz(CUE_ALARM, 3'd0);
            step_elapsed_next  = 8'd0;
          end
        end
        CMD_PLAY: begin
          if (cue <= CUE_ALARM && !(pattern_busy && cue_prio(cue) < busy_priority)) begin
            pattern_cue_next   = cue;
            pattern_busy_next  = 1'b1;
            step_number_next   = 3'd0;
            busy_priority_next = cue_prio(cue);
            tone_reg_next      = cue_hz(cue, 3'd0);
            step_elapsed_next  = 8'd0;
          end
        end
        CMD_ALARM: begin
          if (alarm_request != alarm_mode) begin
            alarm_mode_next = alarm_request;
            if (alarm_request) begin
              alarm_gap_next     = repeat_sat;
              pattern_cue_next   = CUE_ALARM;
              pattern_busy_next  = 1'b1;
              step_number_next   = 3'd0;
              busy_priority_next = PRIO_ALARM;
              tone_reg_next      = cue_hz(CUE_ALARM, 3'd0);
              step_elapsed_next  = 8'd0;
            end else if (pattern_busy && pattern_cue == CUE_ALARM) begin
              pattern_busy_next  = 1'b0;
              step_number_next   = 3'd0;
              busy_priority_next = 3'd0;
              step_elapsed_next  = 8'd0;
              tone_reg_next      = 12'd0;
            end
          end
        end
        CMD_STOP: begin
          pattern_busy_next  = 1'b0;
          step_number_next   = 3'd0;
          busy_priority_next = 3'd0;
          step_elapsed_next  = 8'd0;
          tone_reg_next      = 12'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_busy  <= 1'b0;
      pattern_cue   <= 3'd0;
      step_number   <= 3'd0;
      busy_priority <= 3'd0;
      step_elapsed  <= 8'd0;
      alarm_gap     <= '0;
      alarm_mode    <= 1'b0;
      tone_reg      <= 12'd0;
    end else begin
      pattern_busy  <= pattern_busy_next;
      pattern_cue   <= pattern_cue_next;
      step_number   <= step_number_next;
      busy_priority <= busy_priority_next;
      step_elapsed  <= step_elapsed_next;
      alarm_gap     <= alarm_gap_next;
      alarm_mode    <= alarm_mode_next;
      tone_reg      <= tone_reg_next;
    end
  end

  // result reflects the state after this command
  always_comb begin
    res.tone_hz       = enable ? tone_reg_next : 12'd0;
    res.sounding      = pattern_busy_next;
    res.current_cue   = pattern_cue_next;
    res.alarm_latched = alarm_mode_next;
  end

`ifndef SYNTHESIS
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    !pattern_busy |-> (tone_reg == 12'd0 && busy_priority == 3'd0 && step_number == 3'd0))
    else $error("idle sequencer holds tone or step state");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    pattern_busy |-> ({1'b0, step_number} < cue_steps(pattern_cue)))
    else $error("step number beyond pattern length");

  a_prio_matches: assert property (@(posedge clk) disable iff (rst)
    pattern_busy |-> (busy_priority == cue_prio(pattern_cue)))
    else $error("busy priority does not match playing cue");
`endif

endmodule

`default_nettype wire

[design/ptcs_out_buf.sv]
// ----------------------------------------------------------------------------
// ptcs_out_buf - two-entry result buffer
// Head register plus skid register between core and output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcs_out_buf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ptcs_pkg::res_t din,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ptcs_pkg::res_t      dout
);
  import ptcs_pkg::*;

  logic [1:0] count;
  res_t       head;
  res_t       skid;
  logic       pop;

  assign room      = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign dout      = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= skid;
        if (push) begin
          skid <= din;
        end
      end else if (push) begin
        head <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= din;
      end else begin
        skid <= din;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("buffer count lost a word");
`endif

endmodule

`default_nettype wire

[design/priority_tone_cue_sequencer.sv]
// ----------------------------------------------------------------------------
// priority_tone_cue_sequencer - buzzer cue sequencer with priorities
// Plays ROM tone patterns on command, times steps on 1 ms ticks, and
// replays the alarm pattern after a configurable idle gap.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  -------  ---  ------------------  -----------------------------------------
//  s_*      in   s_tvalid/s_tready   tuser: cmd; tdata: cue, alarm_request
//  m_*      out  m_tvalid/m_tready   tdata: tone_hz, sounding, cue, alarm
//  cfg_*    in   cfg_valid/cfg_ready index 0 enable, index 1 alarm_repeat_ms
//
//  One command word per clock while s_tready is high. Each accepted word updates
//  the sequencer state in that cycle and its result word is registered in the buffer.
//  A two-entry result buffer lets input flow while the output is stalled;
//  s_tready drops only when both entries hold unread results.
//  Synchronous active-high reset sets sequencer, config and buffer count; no clearing pass.
//  cfg_ready is always high; write config only while the block is idle.
//
`default_nettype none

module priority_tone_cue_sequencer #(
  parameter int GAP_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [2:0] cue, [3] alarm_request, [7:4] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] cmd
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [11:0] tone_hz, [12] sounding,
                                      // [15:13] current_cue, [16] alarm_latched,
                                      // [23:17] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import ptcs_pkg::*;

  logic  accept;
  res_t  res;
  res_t  res_out;
  logic  room;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign accept    = s_tvalid && room;

  ptcs_core #(
    .GAP_BITS (GAP_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .cmd           (cmd_t'(s_tuser)),
    .cue           (s_tdata[2:0]),
    .alarm_request (s_tdata[3]),
    .res           (res)
  );

  // result register with skid entry
  ptcs_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (res_out)
  );

  assign m_tdata = {7'd0, res_out};

endmodule

`default_nettype wire

[verif/priority_tone_cue_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_tone_cue_sequencer_tb - self-checking bench for the cue sequencer
// Streams command words through the block with random gaps and output
// stalls, predicts every result word from a local copy of the pattern ROM,
// priorities and alarm timer, and compares each field in order.
// ----------------------------------------------------------------------------

module priority_tone_cue_sequencer_tb;

  import ptcs_pkg::*;

  localparam int GAP_W      = 16;
  localparam int CYCLE_CAP  = 400000;

  // cue codes; the alarm cue comes from the package
  localparam logic [2:0] CUE_SELECT   = 3'd0;
  localparam logic [2:0] CUE_BACK     = 3'd1;
  localparam logic [2:0] CUE_SUCCESS  = 3'd2;
  localparam logic [2:0] CUE_WARNING  = 3'd3;
  localparam logic [2:0] CUE_JOB_DONE = 3'd4;
  localparam logic [2:0] CUE_BAD_LO   = 3'd6;
  localparam logic [2:0] CUE_BAD_HI   = 3'd7;

  // pattern tables, indexed [cue][step]; listed from cue 5 / step 4 down
  localparam logic [5:0][4:0][11:0] STEP_HZ = {
    {12'd700,  12'd0, 12'd700,  12'd0, 12'd700},   // alarm
    {12'd2800, 12'd0, 12'd2200, 12'd0, 12'd1800},  // job finished
    {12'd0,    12'd0, 12'd1000, 12'd0, 12'd1000},  // warning
    {12'd0,    12'd0, 12'd2400, 12'd0, 12'd1800},  // success
    {12'd0,    12'd0, 12'd0,    12'd0, 12'd1400},  // back
    {12'd0,    12'd0, 12'd0,    12'd0, 12'd2400}   // select
  };
  localparam logic [5:0][4:0][7:0] STEP_MS = {
    {8'd250, 8'd120, 8'd250, 8'd120, 8'd250},
    {8'd150, 8'd80,  8'd100, 8'd80,  8'd100},
    {8'd0,   8'd0,   8'd180, 8'd100, 8'd180},
    {8'd0,   8'd0,   8'd90,  8'd45,  8'd70},
    {8'd0,   8'd0,   8'd0,   8'd0,   8'd60},
    {8'd0,   8'd0,   8'd0,   8'd0,   8'd35}
  };
  localparam logic [5:0][2:0] PATTERN_LEN = {3'd5, 3'd5, 3'd3, 3'd3, 3'd1, 3'd1};
  localparam logic [5:0][2:0] PATTERN_PRIO = {3'd5, 3'd3, 3'd4, 3'd2, 3'd1, 3'd1};

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] cue;
    logic       req;
  } cmd_word_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // [2:0] cue, [3] alarm_request, [7:4] zero
  logic [1:0]  s_tuser = 2'd0;    // [1:0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [11:0] tone_hz, [12] sounding,
                                  // [15:13] current_cue, [16] alarm_latched
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  // bench state
  cmd_word_t cmd_q[$];            // words waiting for the driver
  res_t      tone_expect_q[$];    // predicted result words, oldest first
  int        words_outstanding = 0;
  int        errors = 0;
  int        cycles = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;
  logic      cmd_taken = 1'b0;

  // sequencer shadow state and register copies
  logic             seq_busy, seq_alarm;
  logic [2:0]       seq_cue, seq_step, seq_prio;
  logic [7:0]       seq_elapsed;
  logic [GAP_W-1:0] seq_gap;
  logic [11:0]      seq_tone;
  logic             en_cfg;
  logic [15:0]      repeat_cfg;

  priority_tone_cue_sequencer #(
    .GAP_BITS(GAP_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow sequencer
  // ---------------------------------------------------------------------------

  function automatic void seq_silence();
    seq_busy    = 1'b0;
    seq_step    = '0;
    seq_prio    = '0;
    seq_elapsed = '0;
    seq_tone    = '0;
  endfunction

  // lower priority is refused while busy; equal or higher restarts at step 0
  function automatic void seq_start_cue(logic [2:0] c);
    if (c > CUE_ALARM) begin
      return;
    end
    if (seq_busy && PATTERN_PRIO[c] < seq_prio) begin
      return;
    end
    seq_cue     = c;
    seq_busy    = 1'b1;
    seq_step    = '0;
    seq_prio    = PATTERN_PRIO[c];
    seq_tone    = STEP_HZ[c][0];
    seq_elapsed = '0;
  endfunction

  function automatic void seq_tick();
    logic [7:0] dur;
    logic [2:0] steps;
    if (seq_gap != '1) begin
      seq_gap++;
    end
    if (seq_busy) begin
      dur   = STEP_MS[seq_cue][seq_step];
      steps = PATTERN_LEN[seq_cue] > 3'(MAX_PATTERN_STEPS) ?
              3'(MAX_PATTERN_STEPS) : PATTERN_LEN[seq_cue];
      if (seq_elapsed != 8'd255) begin
        seq_elapsed++;
      end
      if (seq_elapsed >= dur) begin
        seq_step++;
        if (seq_step >= steps) begin
          // end of the alarm pattern restarts the repeat gap
          if (seq_cue == CUE_ALARM) begin
            seq_gap = '0;
          end
          seq_silence();
        end else begin
          seq_tone    = STEP_HZ[seq_cue][seq_step];
          seq_elapsed = '0;
        end
      end
    end
    if (seq_alarm && !seq_busy && seq_gap >= repeat_cfg) begin
      seq_start_cue(CUE_ALARM);
    end
  endfunction

  // one command word in, one result word out; disabled block freezes state
  function automatic res_t seq_apply(cmd_t c, logic [2:0] cue, logic req);
    res_t r;
    if (en_cfg) begin
      case (c)
        CMD_TICK: begin
          seq_tick();
        end
        CMD_PLAY: begin
          seq_start_cue(cue);
        end
        CMD_ALARM: begin
          if (req != seq_alarm) begin
            seq_alarm = req;
            if (req) begin
              seq_gap = GAP_W'(repeat_cfg);
              seq_start_cue(CUE_ALARM);
            end else if (seq_busy && seq_cue == CUE_ALARM) begin
              seq_silence();
            end
          end
        end
        default: begin
          seq_silence();
        end
      endcase
    end
    r.tone_hz       = en_cfg ? seq_tone : 12'd0;
    r.sounding      = seq_busy;
    r.current_cue   = seq_cue;
    r.alarm_latched = seq_alarm;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: next word at the falling edge once the last one is taken
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : drive_cmd
    cmd_word_t next_word;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !cmd_taken) begin
      // hold the word until it is accepted
    end else if (send_gap != 0) begin
      s_tvalid <= 1'b0;
      send_gap--;
    end else if (cmd_q.size() != 0) begin
      next_word = cmd_q.pop_front();
      s_tvalid <= 1'b1;
      s_tuser  <= next_word.cmd;
      s_tdata  <= {4'd0, next_word.req, next_word.cue};
      words_outstanding++;
      if (idle_on && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 11);
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted command, check each accepted result
  // ---------------------------------------------------------------------------

  task automatic flag_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= s_tvalid && s_tready;
      // predict first so a same-edge result still finds its expectation
      if (s_tvalid && s_tready) begin
        tone_expect_q.push_back(seq_apply(cmd_t'(s_tuser), s_tdata[2:0], s_tdata[3]));
      end
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[16:0]);
        words_outstanding--;
        if (tone_expect_q.size() == 0) begin
          errors++;
          $display("%0t: result word with no command pending, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = tone_expect_q.pop_front();
          flag_field("tone_hz", want.tone_hz, got.tone_hz);
          flag_field("sounding", want.sounding, got.sounding);
          flag_field("current_cue", want.current_cue, got.current_cue);
          flag_field("alarm_latched", want.alarm_latched, got.alarm_latched);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // unused cue and request fields get random values so those input bits toggle
  task automatic push_word(cmd_t c, logic [2:0] cue, logic req);
    cmd_word_t w;
    w.cmd = c;
    w.cue = cue;
    w.req = req;
    cmd_q.push_back(w);
  endtask

  task automatic push_cmd(cmd_t c);
    push_word(c, 3'($urandom_range(0, 7)), 1'($urandom));
  endtask

  // mostly ticks so patterns run to their ends; calm mode leaves out
  // anything that would cut a running alarm short
  task automatic queue_random_words(int n, int tick_pct, bit calm);
    int         pick;
    logic [2:0] cue;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) begin
        push_cmd(CMD_TICK);
      end else if (calm) begin
        cue = 3'($urandom_range(0, 6));
        push_word(CMD_PLAY, cue == CUE_ALARM ? CUE_BAD_HI : cue, 1'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          push_word(CMD_PLAY, 3'($urandom_range(0, 7)), 1'($urandom));
        end else if (pick < 80) begin
          push_cmd(CMD_ALARM);
        end else begin
          push_cmd(CMD_STOP);
        end
      end
    end
  endtask

  // all queued words sent and every result back
  task automatic wait_idle();
    do @(negedge clk); while (cmd_q.size() != 0 || words_outstanding != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ENABLE) begin
      en_cfg = val[0];
    end else begin
      repeat_cfg = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    seq_busy    = 1'b0;
    seq_alarm   = 1'b0;
    seq_cue     = '0;
    seq_step    = '0;
    seq_prio    = '0;
    seq_elapsed = '0;
    seq_gap     = '0;
    seq_tone    = '0;
    en_cfg      = 1'b0;
    repeat_cfg  = REPEAT_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // block still disabled after reset: state frozen, tone reads zero
    push_word(CMD_PLAY, CUE_SUCCESS, 1'b0);
    push_word(CMD_ALARM, CUE_BAD_HI, 1'b1);
    push_cmd(CMD_TICK);
    push_cmd(CMD_STOP);
    wait_idle();

    // repeat gap at its top so the alarm timer sits saturated
    cfg_write(CFG_REPEAT, 16'hFFFF);
    cfg_write(CFG_ENABLE, {15'($urandom), 1'b1});

    push_word(CMD_PLAY, CUE_SELECT, 1'b1);
    push_word(CMD_PLAY, CUE_BACK, 1'b0);      // equal priority restarts
    push_word(CMD_PLAY, CUE_SUCCESS, 1'b1);
    push_word(CMD_PLAY, CUE_SELECT, 1'b0);    // refused, lower priority
    push_word(CMD_PLAY, CUE_WARNING, 1'b1);
    push_word(CMD_PLAY, CUE_JOB_DONE, 1'b0);  // refused, warning outranks it
    push_word(CMD_PLAY, CUE_BAD_LO, 1'b1);    // unknown cues ignored
    push_word(CMD_PLAY, CUE_BAD_HI, 1'b0);
    push_cmd(CMD_TICK);
    push_cmd(CMD_STOP);
    push_word(CMD_ALARM, CUE_BAD_LO, 1'b0);   // already off
    push_word(CMD_ALARM, CUE_SELECT, 1'b1);   // alarm starts at once
    push_word(CMD_ALARM, CUE_BACK, 1'b1);     // already on
    push_word(CMD_PLAY, CUE_WARNING, 1'b0);   // refused by the alarm
    push_cmd(CMD_TICK);                       // gap stays saturated
    push_word(CMD_ALARM, CUE_BAD_HI, 1'b0);   // off stops the alarm pattern
    push_word(CMD_PLAY, CUE_JOB_DONE, 1'b1);
    push_word(CMD_ALARM, CUE_SUCCESS, 1'b1);  // alarm preempts job finished
    push_cmd(CMD_STOP);                       // silent, alarm mode stays on
    push_word(CMD_PLAY, CUE_SUCCESS, 1'b0);
    push_word(CMD_ALARM, CUE_WARNING, 1'b0);  // off leaves success playing
    push_cmd(CMD_TICK);
    wait_idle();

    // zero gap: alarm replays on the same tick that ends it
    cfg_write(CFG_REPEAT, 16'd0);
    queue_random_words(100, 75, 1'b0);
    wait_idle();

    // long tick run so a whole alarm pattern ends and replays after the gap
    cfg_write(CFG_REPEAT, 16'd40);
    push_word(CMD_ALARM, CUE_BAD_LO, 1'b0);
    push_word(CMD_ALARM, CUE_BAD_HI, 1'b1);
    queue_random_words(1100, 97, 1'b1);
    wait_idle();

    // disabled mid-run: everything frozen
    cfg_write(CFG_ENABLE, {15'($urandom), 1'b0});
    queue_random_words(30, 50, 1'b0);
    wait_idle();

    // back to reset gap, no idling for the tail
    cfg_write(CFG_REPEAT, REPEAT_RESET);
    cfg_write(CFG_ENABLE, {15'($urandom), 1'b1});
    idle_on = 1'b0;
    queue_random_words(80, 80, 1'b0);
    wait_idle();

    repeat (4) @(posedge clk);
    if (tone_expect_q.size() != 0) begin
      errors++;
      $display("%0t: %0d result words never arrived", $time, tone_expect_q.size());
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
